// ===== hdl/tkvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkvt_pkg
// Shared types and constants of the key=value record tokenizer.
// ----------------------------------------------------------------------------
package tkvt_pkg;

  localparam int unsigned PrefixMaxBytesDefault = 8;
  localparam int unsigned FifoDepthDefault      = 4;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PlenW  = 4;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned DataW  = 64;
  localparam int unsigned RegIdxW = 3;

  localparam logic [ByteW-1:0] FieldSepReset = 8'd9;
  localparam logic [ByteW-1:0] RecordSepReset = 8'd10;
  localparam logic [ByteW-1:0] KeyValSepReset = 8'd61;
  localparam logic [PlenW-1:0] PrefixLenReset = 4'd0;

  typedef enum logic [2:0] {
    EV_BEGIN        = 3'd0,
    EV_KEY_BYTE     = 3'd1,
    EV_KEY_END      = 3'd2,
    EV_VALUE_BYTE   = 3'd3,
    EV_VALUE_END    = 3'd4,
    EV_RECORD_END   = 3'd5,
    EV_PREFIX_ERROR = 3'd6
  } event_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_FIELD_SEP  = 3'd0,
    REG_RECORD_SEP = 3'd1,
    REG_KV_SEP     = 3'd2,
    REG_PREFIX     = 3'd3,
    REG_PREFIX_LEN = 3'd4
  } reg_e;

  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // one queued command: one or two events of a single input transaction
  typedef struct packed {
    event_e           ev0;
    event_e           ev1;
    logic [ByteW-1:0] ch;
    logic             two;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] field_sep;
    logic [ByteW-1:0] record_sep;
    logic [ByteW-1:0] kv_sep;
    logic [PlenW-1:0] prefix_len;
  } sep_cfg_t;

  typedef struct packed {
    logic             wr;
    logic [PlenW-1:0] value;
  } plen_wr_t;

endpackage

// ===== hdl/tsv_key_value_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsv_key_value_tokenizer_unit
// Streaming key=value record tokenizer: emits begin/key/value/end events
// per input byte, with an optional checked line prefix.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------
//  input     | push / full               | operation_i, data_byte_i
//  result    | empty / pop               | event_res_o, char_out_o, last_o
//  config    | psel penable pwrite pready| paddr, pwdata, prdata (64 bit)
//
//  one input transaction per cycle while full is low; a transaction with two
//  events holds the command queue head until its second event is loaded
//  a result is registered in the command queue and then in the result register
//  full rises when the command queue (FIFO_DEPTH entries) is full
//  reset is asynchronous: registers to defaults, queue and result empty
// ----------------------------------------------------------------------------
module tsv_key_value_tokenizer_unit
  import tkvt_pkg::*;
#(
  parameter int unsigned PREFIX_MAX_BYTES = PrefixMaxBytesDefault,
  parameter int unsigned FIFO_DEPTH       = FifoDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             operation_i,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       event_res_o,
  output logic [ByteW-1:0] char_out_o,
  output logic             last_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int unsigned PrefixW = PREFIX_MAX_BYTES * ByteW;

  sep_cfg_t                                   cfg_q;
  logic [PREFIX_MAX_BYTES-1:0][ByteW-1:0]     prefix_q;
  logic                                       wr_en;
  reg_e                                       idx;
  plen_wr_t                                   plen_wr;
  logic                                       q_full, q_empty, q_pop, cmd_push;
  cmd_t                                       cmd, head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_e'(paddr[AddrW-1:AddrW-RegIdxW]);

  assign plen_wr.wr    = wr_en && (idx == REG_PREFIX_LEN);
  assign plen_wr.value = pwdata[PlenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.field_sep  <= FieldSepReset;
      cfg_q.record_sep <= RecordSepReset;
      cfg_q.kv_sep     <= KeyValSepReset;
      cfg_q.prefix_len <= PrefixLenReset;
      prefix_q         <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_FIELD_SEP:  cfg_q.field_sep  <= pwdata[ByteW-1:0];
        REG_RECORD_SEP: cfg_q.record_sep <= pwdata[ByteW-1:0];
        REG_KV_SEP:     cfg_q.kv_sep     <= pwdata[ByteW-1:0];
        REG_PREFIX:     prefix_q         <= pwdata[PrefixW-1:0];
        REG_PREFIX_LEN: cfg_q.prefix_len <= pwdata[PlenW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIELD_SEP:  prdata = DataW'(cfg_q.field_sep);
      REG_RECORD_SEP: prdata = DataW'(cfg_q.record_sep);
      REG_KV_SEP:     prdata = DataW'(cfg_q.kv_sep);
      REG_PREFIX:     prdata = DataW'(prefix_q);
      REG_PREFIX_LEN: prdata = DataW'(cfg_q.prefix_len);
      default:        prdata = '0;
    endcase
  end

  assign full = q_full;

  tkvt_front #(
    .PrefixMaxBytes(PREFIX_MAX_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .operation_i(operation_i),
    .data_byte_i(data_byte_i),
    .q_full_i   (q_full),
    .cfg_i      (cfg_q),
    .prefix_i   (prefix_q),
    .plen_wr_i  (plen_wr),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd)
  );

  tkvt_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_push),
    .wdata_i (cmd),
    .rd_i    (q_pop),
    .rdata_o (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tkvt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .event_res_o(event_res_o),
    .char_out_o (char_out_o),
    .last_o     (last_o)
  );

endmodule

// ===== hdl/tkvt_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkvt_fifo
// Short command queue between the parser front and the event back end.
// ----------------------------------------------------------------------------
module tkvt_fifo
  import tkvt_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  input  logic rd_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/tkvt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkvt_front
// Accepts input transactions, tracks the parse phase and prefix match, and
// queues the events that each transaction causes.
// ----------------------------------------------------------------------------
module tkvt_front
  import tkvt_pkg::*;
#(
  parameter int unsigned PrefixMaxBytes = PrefixMaxBytesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic                                operation_i,
  input  logic [ByteW-1:0]                    data_byte_i,
  input  logic                                q_full_i,
  input  sep_cfg_t                            cfg_i,
  input  logic [PrefixMaxBytes-1:0][ByteW-1:0] prefix_i,
  input  plen_wr_t                            plen_wr_i,
  output logic                                cmd_push_o,
  output cmd_t                                cmd_o
);

  localparam int unsigned CntW = $clog2(PrefixMaxBytes + 1);
  localparam int unsigned IdxW = (PrefixMaxBytes > 1) ? $clog2(PrefixMaxBytes) : 1;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_KEY    = 2'd1,
    PH_VALUE  = 2'd2,
    PH_ERROR  = 2'd3
  } phase_e;

  function automatic logic [CntW-1:0] eff_len(input logic [PlenW-1:0] l);
    if (l > PlenW'(PrefixMaxBytes)) begin
      return CntW'(PrefixMaxBytes);
    end
    return l[CntW-1:0];
  endfunction

  phase_e          phase_q, phase_d, start_ph;
  logic            nb_q, nb_d;
  logic [CntW-1:0] cnt_q, cnt_d, eff;
  logic            mism_q, mism_d;
  logic            accept, is_rs, is_fs;
  logic [1:0]      n;
  cmd_t            cmd;

  assign accept   = push_i && !q_full_i;
  assign eff      = eff_len(cfg_i.prefix_len);
  assign start_ph = (eff != '0) ? PH_PREFIX : PH_KEY;
  assign is_rs    = (data_byte_i == cfg_i.record_sep);
  assign is_fs    = (data_byte_i == cfg_i.field_sep);

  always_comb begin
    phase_d = phase_q;
    nb_d    = nb_q;
    cnt_d   = cnt_q;
    mism_d  = mism_q;
    n       = 2'd0;
    cmd.ev0 = EV_BEGIN;
    cmd.ev1 = EV_BEGIN;
    cmd.ch  = data_byte_i;
    cmd.two = 1'b0;
    if (accept) begin
      if (operation_i == OP_FINISH) begin
        if (phase_q == PH_VALUE) begin
          cmd.ev0 = EV_VALUE_END;
          cmd.ev1 = EV_RECORD_END;
          n       = 2'd2;
          nb_d    = 1'b1;
          cnt_d   = '0;
          mism_d  = 1'b0;
          phase_d = start_ph;
        end
      end else begin
        case (phase_q)
          PH_PREFIX: begin
            if (nb_q) begin
              n    = 2'd1;
              nb_d = 1'b0;
            end
            if (is_rs || is_fs) begin
              if (mism_q || cnt_q != eff) begin
                if (n == 2'd0) begin
                  cmd.ev0 = EV_PREFIX_ERROR;
                end else begin
                  cmd.ev1 = EV_PREFIX_ERROR;
                end
                n       = n + 2'd1;
                phase_d = PH_ERROR;
              end else if (is_rs) begin
                if (n == 2'd0) begin
                  cmd.ev0 = EV_RECORD_END;
                end else begin
                  cmd.ev1 = EV_RECORD_END;
                end
                n       = n + 2'd1;
                nb_d    = 1'b1;
                cnt_d   = '0;
                mism_d  = 1'b0;
                phase_d = start_ph;
              end else begin
                cnt_d   = '0;
                phase_d = PH_KEY;
              end
            end else if (!mism_q) begin
              if (cnt_q < eff && prefix_i[cnt_q[IdxW-1:0]] == data_byte_i) begin
                cnt_d = cnt_q + 1'b1;
              end else begin
                mism_d = 1'b1;
              end
            end
          end
          PH_KEY: begin
            if (nb_q) begin
              n    = 2'd1;
              nb_d = 1'b0;
            end
            if (n == 2'd0) begin
              cmd.ev0 = (data_byte_i == cfg_i.kv_sep) ? EV_KEY_END : EV_KEY_BYTE;
            end else begin
              cmd.ev1 = (data_byte_i == cfg_i.kv_sep) ? EV_KEY_END : EV_KEY_BYTE;
            end
            n = n + 2'd1;
            if (data_byte_i == cfg_i.kv_sep) begin
              phase_d = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (is_rs) begin
              cmd.ev0 = EV_VALUE_END;
              cmd.ev1 = EV_RECORD_END;
              n       = 2'd2;
              nb_d    = 1'b1;
              cnt_d   = '0;
              mism_d  = 1'b0;
              phase_d = start_ph;
            end else if (is_fs) begin
              cmd.ev0 = EV_VALUE_END;
              n       = 2'd1;
              phase_d = PH_KEY;
            end else begin
              cmd.ev0 = EV_VALUE_BYTE;
              n       = 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (plen_wr_i.wr && nb_q && phase_q != PH_ERROR) begin
      phase_d = (eff_len(plen_wr_i.value) != '0) ? PH_PREFIX : PH_KEY;
    end
    cmd.two = (n == 2'd2);
  end

  // command enters the queue at the accepting edge
  assign cmd_push_o = (n != 2'd0);
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= (eff_len(PrefixLenReset) != '0) ? PH_PREFIX : PH_KEY;
      nb_q    <= 1'b1;
      cnt_q   <= '0;
      mism_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      nb_q    <= nb_d;
      cnt_q   <= cnt_d;
      mism_q  <= mism_d;
    end
  end

endmodule

// ===== hdl/tkvt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkvt_back
// Takes queued commands and delivers their events one per transaction
// through the result register.
// ----------------------------------------------------------------------------
module tkvt_back
  import tkvt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             head_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [2:0]       event_res_o,
  output logic [ByteW-1:0] char_out_o,
  output logic             last_o
);

  logic             vld_q, vld_d;
  logic             sub_q, sub_d;
  event_e           ev_q, ev_d;
  logic [ByteW-1:0] ch_q, ch_d;
  logic             last_q, last_d;
  logic             load;

  assign load = !vld_q || pop_i;

  always_comb begin
    vld_d   = vld_q;
    sub_d   = sub_q;
    ev_d    = ev_q;
    ch_d    = ch_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    if (load) begin
      vld_d = !q_empty_i;
      if (!q_empty_i) begin
        ev_d   = sub_q ? head_i.ev1 : head_i.ev0;
        ch_d   = (ev_d == EV_KEY_BYTE || ev_d == EV_VALUE_BYTE) ? head_i.ch : '0;
        last_d = !head_i.two || sub_q;
        if (head_i.two && !sub_q) begin
          sub_d = 1'b1;
        end else begin
          sub_d   = 1'b0;
          q_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sub_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      sub_q <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  assign empty_o     = !vld_q;
  assign event_res_o = ev_q;
  assign char_out_o  = ch_q;
  assign last_o      = last_q;

endmodule

// ===== hdl/tkvt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkvt_checker
// Port-level checks of the tokenizer result stream.
// ----------------------------------------------------------------------------
module tkvt_checker
  import tkvt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input logic [2:0]       event_res_o,
  input logic [ByteW-1:0] char_out_o,
  input logic             last_o
);

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_res_o != EV_KEY_BYTE && event_res_o != EV_VALUE_BYTE)
      |-> (char_out_o == '0))
    else $error("char_out nonzero on a non-byte event");

  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(event_res_o) && $stable(char_out_o)
      && $stable(last_o)))
    else $error("stalled result changed");

  a_rec_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (event_res_o == EV_RECORD_END || event_res_o == EV_PREFIX_ERROR))
      |-> last_o)
    else $error("record end or prefix error not last");

  a_begin_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (event_res_o == EV_BEGIN || event_res_o == EV_VALUE_END) && !last_o
      && pop) |=> (!empty))
    else $error("first of two events not followed by its second");

  a_key_value_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (event_res_o == EV_KEY_BYTE || event_res_o == EV_KEY_END
      || event_res_o == EV_VALUE_BYTE)) |-> last_o)
    else $error("key or value event not last");

endmodule

bind tsv_key_value_tokenizer_unit tkvt_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .event_res_o(event_res_o),
  .char_out_o (char_out_o),
  .last_o     (last_o)
);

// ===== tb/sv/tb_tsv_key_value_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tsv_key_value_tokenizer_unit
// Self-checking bench for the key=value record tokenizer. A scoreboard class
// tracks separators, prefix and parse state, predicts the event stream of
// every accepted input transaction and compares each popped result field by
// field. Directed records come first at reset and extreme settings, then
// mostly well-formed random records over a series of register settings, with
// random stalls on both queue sides; the sticky prefix error closes the run.
// ----------------------------------------------------------------------------
module tb_tsv_key_value_tokenizer_unit;
  import tkvt_pkg::*;

  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ItemsPerPhase = 125;
  localparam int unsigned MaxGap        = 18;

  typedef enum logic [1:0] {
    PHASE_PREFIX,
    PHASE_KEY,
    PHASE_VALUE,
    PHASE_ERROR
  } parse_phase_e;

  typedef struct packed {
    event_e           ev;
    logic [ByteW-1:0] ch;
    logic             last;
  } token_event_t;

  class kv_event_scoreboard;
    logic [ByteW-1:0] field_sep;
    logic [ByteW-1:0] record_sep;
    logic [ByteW-1:0] kv_sep;
    logic [DataW-1:0] prefix_bytes;
    logic [PlenW-1:0] prefix_len;
    parse_phase_e     phase;
    bit               record_idle;
    int unsigned      match_count;
    bit               mismatch;
    bit               saw_prefix_error;
    token_event_t     expected_q[$];
    int unsigned      n_inputs;
    int unsigned      n_results;
    int unsigned      n_writes;
    int unsigned      n_errors;

    function new();
      field_sep        = FieldSepReset;
      record_sep       = RecordSepReset;
      kv_sep           = KeyValSepReset;
      prefix_bytes     = '0;
      prefix_len       = PrefixLenReset;
      saw_prefix_error = 1'b0;
      n_inputs         = 0;
      n_results        = 0;
      n_writes         = 0;
      n_errors         = 0;
      close_record();
    endfunction

    function int unsigned active_prefix_len();
      return (prefix_len > PrefixMaxBytesDefault) ? PrefixMaxBytesDefault : prefix_len;
    endfunction

    function parse_phase_e first_phase();
      return (active_prefix_len() != 0) ? PHASE_PREFIX : PHASE_KEY;
    endfunction

    function void close_record();
      record_idle = 1'b1;
      match_count = 0;
      mismatch    = 1'b0;
      phase       = first_phase();
    endfunction

    function token_event_t mk_event(event_e ev, logic [ByteW-1:0] ch);
      token_event_t e;
      e.ev   = ev;
      e.ch   = ch;
      e.last = 1'b0;
      return e;
    endfunction

    function void write_reg(reg_e idx, logic [DataW-1:0] value);
      n_writes++;
      case (idx)
        REG_FIELD_SEP:  field_sep = value[ByteW-1:0];
        REG_RECORD_SEP: record_sep = value[ByteW-1:0];
        REG_KV_SEP:     kv_sep = value[ByteW-1:0];
        REG_PREFIX:     prefix_bytes = value;
        REG_PREFIX_LEN: begin
          prefix_len = value[PlenW-1:0];
          if (record_idle && phase != PHASE_ERROR) phase = first_phase();
        end
        default: ;
      endcase
    endfunction

    function logic [DataW-1:0] reg_value(reg_e idx);
      case (idx)
        REG_FIELD_SEP:  return DataW'(field_sep);
        REG_RECORD_SEP: return DataW'(record_sep);
        REG_KV_SEP:     return DataW'(kv_sep);
        REG_PREFIX:     return prefix_bytes;
        REG_PREFIX_LEN: return DataW'(prefix_len);
        default:        return '0;
      endcase
    endfunction

    function void predict_events(logic op, logic [ByteW-1:0] b);
      token_event_t evs[$];
      n_inputs++;
      if (op == OP_FINISH) begin
        if (phase == PHASE_VALUE) begin
          evs.push_back(mk_event(EV_VALUE_END, '0));
          evs.push_back(mk_event(EV_RECORD_END, '0));
          close_record();
        end
      end else begin
        case (phase)
          PHASE_PREFIX: begin
            if (record_idle) begin
              evs.push_back(mk_event(EV_BEGIN, '0));
              record_idle = 1'b0;
            end
            if (b == record_sep || b == field_sep) begin
              if (mismatch || match_count != active_prefix_len()) begin
                evs.push_back(mk_event(EV_PREFIX_ERROR, '0));
                phase            = PHASE_ERROR;
                saw_prefix_error = 1'b1;
              end else if (b == record_sep) begin
                evs.push_back(mk_event(EV_RECORD_END, '0));
                close_record();
              end else begin
                match_count = 0;
                phase       = PHASE_KEY;
              end
            end else if (!mismatch) begin
              if (match_count < active_prefix_len() &&
                  prefix_bytes[8*match_count +: 8] == b) begin
                match_count++;
              end else begin
                mismatch = 1'b1;
              end
            end
          end
          PHASE_KEY: begin
            if (record_idle) begin
              evs.push_back(mk_event(EV_BEGIN, '0));
              record_idle = 1'b0;
            end
            if (b == kv_sep) begin
              evs.push_back(mk_event(EV_KEY_END, '0));
              phase = PHASE_VALUE;
            end else begin
              evs.push_back(mk_event(EV_KEY_BYTE, b));
            end
          end
          PHASE_VALUE: begin
            if (b == record_sep) begin
              evs.push_back(mk_event(EV_VALUE_END, '0));
              evs.push_back(mk_event(EV_RECORD_END, '0));
              close_record();
            end else if (b == field_sep) begin
              evs.push_back(mk_event(EV_VALUE_END, '0));
              phase = PHASE_KEY;
            end else begin
              evs.push_back(mk_event(EV_VALUE_BYTE, b));
            end
          end
          default: ;
        endcase
      end
      if (evs.size() != 0) evs[evs.size()-1].last = 1'b1;
      foreach (evs[i]) expected_q.push_back(evs[i]);
    endfunction

    function void check_event(logic [2:0] ev, logic [ByteW-1:0] ch, logic last);
      token_event_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: event_res %0d char_out %0d last %0d",
               ev, ch, last);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      if (ev !== want.ev) begin
        $error("event_res: expected %0d, got %0d", want.ev, ev);
        n_errors++;
      end
      if (ch !== want.ch) begin
        $error("char_out: expected %0d, got %0d", want.ch, ch);
        n_errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        n_errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic             operation_i;
  logic [ByteW-1:0] data_byte_i;
  logic             empty;
  logic             pop;
  logic [2:0]       event_res_o;
  logic [ByteW-1:0] char_out_o;
  logic             last_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  kv_event_scoreboard sb;
  int unsigned        cycle_count = 0;
  int unsigned        pop_wait = 0;
  bit                 pop_calm = 1'b0;
  bit                 push_calm = 1'b0;

  tsv_key_value_tokenizer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .empty       (empty),
    .pop         (pop),
    .event_res_o (event_res_o),
    .char_out_o  (char_out_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: pop transactions with random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_wait = 0;
    end else begin
      if (pop && !empty) begin
        sb.check_event(event_res_o, char_out_o, last_o);
        if ($urandom_range(0, 39) == 0) pop_calm = !pop_calm;
        pop_wait = pop_calm ? 0 : $urandom_range(0, MaxGap);
      end else if (!pop && pop_wait != 0) begin
        pop_wait--;
      end
      pop <= (pop_wait == 0);
    end
  end

  task automatic send_item(logic op, logic [ByteW-1:0] b);
    int unsigned gap;
    gap = push_calm ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    operation_i <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
    sb.predict_events(op, b);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_access(reg_e idx, logic wr, logic [DataW-1:0] wdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'({idx, 3'b000});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      sb.write_reg(idx, wdata);
    end else if (prdata !== sb.reg_value(idx)) begin
      $error("prdata: expected %0h, got %0h", sb.reg_value(idx), prdata);
      sb.n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    reg_e all_regs[5];
    all_regs = '{REG_FIELD_SEP, REG_RECORD_SEP, REG_KV_SEP, REG_PREFIX, REG_PREFIX_LEN};
    foreach (all_regs[i]) reg_access(all_regs[i], 1'b0, '0);
  endtask

  task automatic apply_settings(logic [ByteW-1:0] fs, logic [ByteW-1:0] rs,
                                logic [ByteW-1:0] kv, logic [PlenW-1:0] plen,
                                logic [DataW-1:0] pbytes);
    logic [DataW-1:0] junk;
    junk = {$urandom(), $urandom()};
    reg_access(REG_FIELD_SEP, 1'b1, {junk[DataW-1:ByteW], fs});
    reg_access(REG_RECORD_SEP, 1'b1, {junk[DataW-1:ByteW], rs});
    reg_access(REG_KV_SEP, 1'b1, {junk[DataW-1:ByteW], kv});
    reg_access(REG_PREFIX, 1'b1, pbytes);
    reg_access(REG_PREFIX_LEN, 1'b1, {junk[DataW-1:PlenW], plen});
    check_all_regs();
  endtask

  task automatic random_settings(int unsigned p);
    logic [ByteW-1:0] fs;
    logic [ByteW-1:0] rs;
    logic [ByteW-1:0] kv;
    logic [ByteW-1:0] pb;
    logic [PlenW-1:0] plen;
    logic [DataW-1:0] pbytes;
    fs   = 8'($urandom_range(0, 255));
    rs   = 8'($urandom_range(0, 255));
    kv   = 8'($urandom_range(0, 255));
    plen = 4'($urandom_range(0, 15));
    case (p)
      0: begin
        fs   = 8'h00;
        rs   = 8'hFF;
        plen = 4'd0;
      end
      1: begin
        rs   = fs;
        plen = 4'd15;
      end
      2: begin
        fs   = 8'hFF;
        kv   = 8'h00;
        plen = 4'd8;
      end
      3: plen = 4'd1;
      RandomPhases: plen = 4'd3;
      default: ;
    endcase
    // prefix bytes never collide with the field or record separator
    for (int i = 0; i < 8; i++) begin
      do pb = 8'($urandom_range(0, 255)); while (pb == fs || pb == rs);
      pbytes[8*i +: 8] = pb;
    end
    apply_settings(fs, rs, kv, plen, pbytes);
  endtask

  function automatic logic [ByteW-1:0] pick_special();
    case ($urandom_range(0, 4))
      0:       return sb.field_sep;
      1:       return sb.record_sep;
      2:       return sb.kv_sep;
      3:       return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  // mostly well-formed records with random content, steered by parse state
  task automatic send_next_item();
    logic             op;
    logic [ByteW-1:0] b;
    int unsigned      r;
    op = OP_DATA;
    b  = 8'($urandom_range(0, 255));
    r  = $urandom_range(0, 99);
    case (sb.phase)
      PHASE_PREFIX: begin
        if (r < 5) op = OP_FINISH;
        else if (sb.match_count < sb.active_prefix_len())
          b = sb.prefix_bytes[8*sb.match_count +: 8];
        else b = (r < 20) ? sb.record_sep : sb.field_sep;
      end
      PHASE_KEY: begin
        if (r < 5) op = OP_FINISH;
        else if (r < 22) b = sb.kv_sep;
        else if (r < 30) b = pick_special();
      end
      PHASE_VALUE: begin
        if (r < 4) op = OP_FINISH;
        else if (r < 16) b = sb.field_sep;
        else if (r < 24) b = sb.record_sep;
        else if (r < 30) b = pick_special();
      end
      default: ;
    endcase
    send_item(op, b);
  endtask

  task automatic close_prefix_token();
    while (sb.phase == PHASE_PREFIX && !sb.record_idle) send_next_item();
  endtask

  task automatic force_prefix_error();
    logic [ByteW-1:0] extra;
    close_prefix_token();
    drain_results();
    random_settings(RandomPhases);
    while (!(sb.phase == PHASE_PREFIX && sb.record_idle)) send_next_item();
    case ($urandom_range(0, 2))
      0: send_item(OP_DATA, sb.prefix_bytes[7:0] ^ 8'h01);
      1: send_item(OP_DATA, sb.prefix_bytes[7:0]);
      default: begin
        for (int i = 0; i < 3; i++) send_item(OP_DATA, sb.prefix_bytes[8*i +: 8]);
        do extra = 8'($urandom_range(0, 255));
        while (extra == sb.field_sep || extra == sb.record_sep);
        send_item(OP_DATA, extra);
      end
    endcase
    send_item(OP_DATA, ($urandom_range(0, 1) == 0) ? sb.field_sep : sb.record_sep);
    // error state is sticky
    repeat (12) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    drain_results();
    reg_access(REG_PREFIX_LEN, 1'b1, '0);
    repeat (6) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    push        = 1'b0;
    operation_i = OP_DATA;
    data_byte_i = '0;
    pop         = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_all_regs();

    // reset separators: extremes, separators inside keys and values, finish cases
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, FieldSepReset);
    send_item(OP_DATA, RecordSepReset);
    send_item(OP_DATA, KeyValSepReset);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, KeyValSepReset);
    send_item(OP_DATA, FieldSepReset);
    send_item(OP_DATA, KeyValSepReset);
    send_item(OP_DATA, RecordSepReset);
    send_item(OP_FINISH, 8'hFF);
    send_item(OP_DATA, 8'h6B);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_DATA, KeyValSepReset);
    send_item(OP_FINISH, 8'h5A);
    drain_results();

    // full-length walking-ones prefix with extreme separators
    apply_settings(8'h00, 8'hFF, 8'h80, 4'd8, 64'h8040_2010_0804_0201);
    for (int i = 0; i < 8; i++) send_item(OP_DATA, 8'(1 << i));
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'hFF);

    for (int p = 0; p < RandomPhases; p++) begin
      close_prefix_token();
      drain_results();
      random_settings(p);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if ($urandom_range(0, 49) == 0) push_calm = !push_calm;
        if (k == ItemsPerPhase / 2) drain_results();
        send_next_item();
      end
    end

    push_calm = 1'b0;
    force_prefix_error();
    drain_results();
    check_all_regs();

    $display("covered %0d input and %0d result transactions with %0d register writes",
             sb.n_inputs, sb.n_results, sb.n_writes);
    $display("%0d separator/prefix settings exercised, prefix error path %s",
             RandomPhases + 3, sb.saw_prefix_error ? "reached" : "not reached");
    if (sb.n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
